FILE: design/assert_macros.svh
// assertion macros for the costmap inflation block
// used by the controller; ASSERT_OFF removes every check
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// property must hold at every rising clock edge out of reset
`define ASSERT_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
// expression must never be true out of reset
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

FILE: design/lsci_pkg.sv
// shared constants, sine table and controller/datapath interface types
// no dependencies
package lsci_pkg;

   localparam int GRID_XW  = 8;
   localparam int GRID_YW  = 8;
   localparam int GRID_AW  = GRID_XW + GRID_YW;
   localparam int GRID_DEPTH = 1 << GRID_AW;
   localparam int COST_W   = 7;
   localparam logic [COST_W-1:0] COST_MAX = 7'd100;
   localparam int MAX_INFL = 16;
   localparam int N_W      = $clog2(MAX_INFL + 1);
   localparam int D_W      = N_W + 1;
   localparam int DIV_W    = 25;
   localparam int DIV_CW   = $clog2(DIV_W + 1);
   localparam int CSR_IW   = 3;

   // register indexes
   localparam logic [CSR_IW-1:0] REG_RANGE_LO = 3'd0;
   localparam logic [CSR_IW-1:0] REG_RANGE_HI = 3'd1;
   localparam logic [CSR_IW-1:0] REG_ASTEP    = 3'd2;
   localparam logic [CSR_IW-1:0] REG_ORG_X    = 3'd3;
   localparam logic [CSR_IW-1:0] REG_ORG_Y    = 3'd4;
   localparam logic [CSR_IW-1:0] REG_CELL     = 3'd5;
   localparam logic [CSR_IW-1:0] REG_RADIUS   = 3'd6;

   // opcodes
   localparam logic [1:0] OP_BEGIN = 2'd0;
   localparam logic [1:0] OP_RANGE = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;
   localparam logic [1:0] OP_NONE  = 2'd3;

   // quarter-wave sine, q14
   localparam logic [14:0] QSINE [0:64] = '{
      15'd0, 15'd402, 15'd804, 15'd1205, 15'd1606, 15'd2006, 15'd2404, 15'd2801,
      15'd3196, 15'd3590, 15'd3981, 15'd4370, 15'd4756, 15'd5139, 15'd5520,
      15'd5897, 15'd6270, 15'd6639, 15'd7005, 15'd7366, 15'd7723, 15'd8076,
      15'd8423, 15'd8765, 15'd9102, 15'd9434, 15'd9760, 15'd10080, 15'd10394,
      15'd10702, 15'd11003, 15'd11297, 15'd11585, 15'd11866, 15'd12140,
      15'd12406, 15'd12665, 15'd12916, 15'd13160, 15'd13395, 15'd13623,
      15'd13842, 15'd14053, 15'd14256, 15'd14449, 15'd14635, 15'd14811,
      15'd14978, 15'd15137, 15'd15286, 15'd15426, 15'd15557, 15'd15679,
      15'd15791, 15'd15893, 15'd15986, 15'd16069, 15'd16143, 15'd16207,
      15'd16261, 15'd16305, 15'd16340, 15'd16364, 15'd16379, 15'd16384
   };

   typedef struct packed {
      logic ld_req;
      logic ang_load;
      logic ang_step;
      logic sel;
      logic trig;
      logic prod;
      logic num_start;
      logic nd_start;
      logic div_step;
      logic g_save;
      logic n_save;
      logic cell_eval;
      logic sc_mul;
      logic need_init;
      logic bs_mul;
      logic bs_cmp;
      logic clr_wr;
      logic rd_cell;
      logic rmw_rd;
      logic rmw_wr;
      logic win_next;
      logic post;
      logic post_mark;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic in_range;
      logic div_done;
      logic grid_ok;
      logic cell_in;
      logic scs_gt;
      logic bs_more;
      logic win_last;
   } sts_type;

endpackage

FILE: design/lsci_ram.sv
// generic single-port ram with registered read
// no dependencies
module lsci_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [0:DEPTH-1];

   // write port and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      if (en) begin
         rdata <= mem[addr];
      end
   end

endmodule

FILE: design/lsci_dp.sv
// datapath: config registers, sine, divider, inflation window and grid memory
// depends on lsci_pkg and lsci_ram
module lsci_dp import lsci_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output sts_type             sts,
   input  logic [1:0]          req_opcode,
   input  logic [15:0]         req_range_value,
   input  logic [31:0]         req_start_angle,
   input  logic [7:0]          req_cell_x,
   input  logic [7:0]          req_cell_y,
   input  logic                csr_valid,
   input  logic [CSR_IW-1:0]   csr_index,
   input  logic [31:0]         csr_wdata,
   output logic [COST_W-1:0]   rsp_cell_cost,
   output logic                rsp_obstacle_marked
);

   // config registers
   logic [15:0] rlo_ff, rhi_ff, cs_ff, rad_ff;
   logic [31:0] astep_ff;
   logic [23:0] orgx_ff, orgy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rlo_ff <= '0; rhi_ff <= 16'hFFFF; astep_ff <= '0;
         orgx_ff <= '0; orgy_ff <= '0; cs_ff <= 16'd26; rad_ff <= 16'd256;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_RANGE_LO: rlo_ff <= csr_wdata[15:0];
            REG_RANGE_HI: rhi_ff <= csr_wdata[15:0];
            REG_ASTEP:    astep_ff <= csr_wdata;
            REG_ORG_X:    orgx_ff <= csr_wdata[23:0];
            REG_ORG_Y:    orgy_ff <= csr_wdata[23:0];
            REG_CELL:     cs_ff <= csr_wdata[15:0];
            REG_RADIUS:   rad_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   logic [15:0] cs_eff;
   assign cs_eff = (cs_ff == 16'd0) ? 16'd1 : cs_ff;

   // latched item and scan angle
   logic [1:0]  op_ff;
   logic [15:0] r_ff;
   logic [7:0]  rx_ff, ry_ff;
   logic [31:0] ang_ff, a_ff;

   always_ff @(posedge clock) begin
      if (cmd.ld_req) begin
         op_ff <= req_opcode; r_ff <= req_range_value;
         rx_ff <= req_cell_x; ry_ff <= req_cell_y; a_ff <= ang_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ang_ff <= '0;
      end else if (cmd.ang_load) begin
         ang_ff <= req_start_angle;
      end else if (cmd.ang_step) begin
         ang_ff <= ang_ff + astep_ff;
      end
   end

   assign sts.in_range = (r_ff >= rlo_ff) && (r_ff <= rhi_ff);

   // table sine with linear interpolation; sel low gives cosine
   logic [31:0] tb;
   logic [30:0] pp;
   logic [6:0]  ti;
   logic [14:0] tdiff, tmag;
   logic [38:0] tprod;
   logic signed [15:0] trig_ff;
   logic signed [32:0] prod_ff;

   always_comb begin
      tb    = cmd.sel ? a_ff : a_ff + 32'h4000_0000;
      pp    = tb[30] ? (31'h4000_0000 - {1'b0, tb[29:0]}) : {1'b0, tb[29:0]};
      ti    = pp[30:24];
      tdiff = '0;
      tprod = '0;
      if (ti >= 7'd64) begin
         tmag = QSINE[64];
      end else begin
         tdiff = QSINE[7'(ti + 7'd1)] - QSINE[ti];
         tprod = 39'(tdiff) * 39'(pp[23:0]);
         tmag  = QSINE[ti] + tprod[38:24];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.trig) begin
         trig_ff <= tb[31] ? -signed'({1'b0, tmag}) : signed'({1'b0, tmag});
      end
      if (cmd.prod) begin
         prod_ff <= signed'({1'b0, r_ff}) * trig_ff;
      end
   end

   // offset by origin, take magnitude and drop the q14 scale
   logic signed [39:0] num, org40;
   logic [39:0] num_mag;
   always_comb begin
      org40   = cmd.sel ? 40'(signed'(orgy_ff)) : 40'(signed'(orgx_ff));
      num     = 40'(prod_ff) - (org40 <<< 14);
      num_mag = num[39] ? 40'(-num) : 40'(num);
   end

   // restoring divider, one quotient bit a cycle
   logic [15:0]       dv_rem, dv_den;
   logic [DIV_W-1:0]  dv_quo;
   logic [DIV_CW-1:0] dv_cnt;
   logic              neg_ff;
   logic [16:0]       dv_t;

   assign dv_t = {dv_rem, dv_quo[DIV_W-1]};
   assign sts.div_done = (dv_cnt == DIV_CW'(DIV_W));

   always_ff @(posedge clock) begin
      if (cmd.num_start) begin
         dv_rem <= '0; dv_den <= cs_eff; dv_cnt <= '0;
         dv_quo <= num_mag[38:14]; neg_ff <= num[39];
      end else if (cmd.nd_start) begin
         dv_rem <= '0; dv_den <= cs_eff; dv_cnt <= '0;
         dv_quo <= DIV_W'(rad_ff);
      end else if (cmd.div_step) begin
         dv_cnt <= dv_cnt + 1'b1;
         if (dv_t >= {1'b0, dv_den}) begin
            dv_rem <= 16'(dv_t - {1'b0, dv_den});
            dv_quo <= {dv_quo[DIV_W-2:0], 1'b1};
         end else begin
            dv_rem <= dv_t[15:0];
            dv_quo <= {dv_quo[DIV_W-2:0], 1'b0};
         end
      end
   end

   // hit cell
   logic [7:0] gx_ff, gy_ff;
   logic       okx_ff, oky_ff, g_ok;

   assign g_ok = (dv_quo < DIV_W'(256)) && (!neg_ff || (dv_quo == '0));
   always_ff @(posedge clock) begin
      if (cmd.g_save) begin
         if (cmd.sel) begin
            gy_ff <= dv_quo[7:0]; oky_ff <= g_ok;
         end else begin
            gx_ff <= dv_quo[7:0]; okx_ff <= g_ok;
         end
      end
   end
   assign sts.grid_ok = okx_ff && oky_ff;

   // inflation window walk
   logic [N_W-1:0]        n_ff;
   logic signed [D_W-1:0] dx_ff, dy_ff, n_s;
   logic [31:0]           cs2_ff, rad2_ff;
   logic signed [9:0]     cx, cy;
   logic [9:0]            s_ff;
   logic [41:0]           scs_ff;
   logic [45:0]           need_ff, kr2;
   logic [6:0]            lo_ff, hi_ff, mid, mid_ff;
   logic [7:0]            lohi;
   logic [22:0]           kr_ff;
   logic [N_W-1:0]        n_new;

   assign n_s   = signed'({1'b0, n_ff});
   assign n_new = (dv_quo > DIV_W'(MAX_INFL)) ? N_W'(MAX_INFL) : dv_quo[N_W-1:0];
   assign cx    = signed'({2'b0, gx_ff}) + 10'(dx_ff);
   assign cy    = signed'({2'b0, gy_ff}) + 10'(dy_ff);
   assign sts.cell_in  = (cx[9:8] == 2'b00) && (cy[9:8] == 2'b00);
   assign sts.win_last = (dx_ff == n_s) && (dy_ff == n_s);
   assign sts.scs_gt   = scs_ff > {10'b0, rad2_ff};
   assign sts.bs_more  = lo_ff < hi_ff;
   assign lohi = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid  = lohi[7:1];
   assign kr2  = 46'(kr_ff) * 46'(kr_ff);

   always_ff @(posedge clock) begin
      if (cmd.n_save) begin
         n_ff    <= n_new;
         dx_ff   <= -signed'({1'b0, n_new});
         dy_ff   <= -signed'({1'b0, n_new});
         cs2_ff  <= cs_eff * cs_eff;
         rad2_ff <= rad_ff * rad_ff;
      end else if (cmd.win_next) begin
         if (dy_ff == n_s) begin
            dy_ff <= -n_s;
            dx_ff <= dx_ff + 1'b1;
         end else begin
            dy_ff <= dy_ff + 1'b1;
         end
      end
      if (cmd.cell_eval) begin
         s_ff <= 10'(dx_ff * dx_ff) + 10'(dy_ff * dy_ff);
      end
      if (cmd.sc_mul) begin
         scs_ff <= 42'(s_ff) * 42'(cs2_ff);
      end
      if (cmd.need_init) begin
         need_ff <= 46'(scs_ff[31:0]) * 46'(14'd10000);
         lo_ff   <= '0;
         hi_ff   <= COST_MAX;
      end else if (cmd.bs_cmp) begin
         if (kr2 >= need_ff) begin
            hi_ff <= mid_ff;
         end else begin
            lo_ff <= mid_ff + 1'b1;
         end
      end
      if (cmd.bs_mul) begin
         kr_ff  <= 23'(mid) * 23'(rad_ff);
         mid_ff <= mid;
      end
   end

   // clearing sweep address
   logic [GRID_AW-1:0] clr_ff;
   assign sts.clr_last = (clr_ff == {GRID_AW{1'b1}});
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clr_wr) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   // grid memory port
   logic               ram_en, ram_we;
   logic [GRID_AW-1:0] ram_addr;
   logic [COST_W-1:0]  ram_wdata, ram_rdata, new_cost;

   assign new_cost = COST_MAX - lo_ff;
   always_comb begin
      ram_en    = cmd.rd_cell || cmd.rmw_rd;
      ram_we    = cmd.clr_wr || (cmd.rmw_wr && (new_cost > ram_rdata));
      ram_wdata = cmd.clr_wr ? '0 : new_cost;
      priority if (cmd.clr_wr) begin
         ram_addr = clr_ff;
      end else if (cmd.rd_cell) begin
         ram_addr = {ry_ff, rx_ff};
      end else begin
         ram_addr = {cy[GRID_YW-1:0], cx[GRID_XW-1:0]};
      end
   end

   lsci_ram #(.WIDTH(COST_W), .DEPTH(GRID_DEPTH)) u_grid (
      .clock (clock),
      .en    (ram_en),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // result register
   always_ff @(posedge clock) begin
      if (cmd.post) begin
         rsp_cell_cost       <= (op_ff == OP_READ) ? ram_rdata : '0;
         rsp_obstacle_marked <= cmd.post_mark;
      end
   end

endmodule

FILE: design/lsci_ctrl.sv
// controller: sequences clearing, projection, inflation walk and reads
// depends on lsci_pkg and assert_macros.svh
`include "assert_macros.svh"
module lsci_ctrl import lsci_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_opcode,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output cmd_type    cmd,
   input  sts_type    sts
);

   localparam logic [4:0] S_CLR  = 5'd0,  S_IDLE = 5'd1,  S_RD0  = 5'd2,
                          S_RD1  = 5'd3,  S_DONE = 5'd4,  S_RNG  = 5'd5,
                          S_TRIG = 5'd6,  S_PROD = 5'd7,  S_NUM  = 5'd8,
                          S_DIV  = 5'd9,  S_NDIV = 5'd10, S_NSAV = 5'd11,
                          S_CELL = 5'd12, S_SC   = 5'd13, S_CHK  = 5'd14,
                          S_BS0  = 5'd15, S_BS1  = 5'd16, S_RMW0 = 5'd17,
                          S_RMW1 = 5'd18, S_NEXT = 5'd19;

   logic [4:0] state_ff, state_in;
   logic       sel_ff, sel_in, mark_ff, mark_in, post_ff, post_in;
   logic       rsp_valid_ff, rsp_valid_in, slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      sel_in   = sel_ff;
      mark_in  = mark_ff;
      post_in  = post_ff;
      cmd      = '0;
      cmd.sel  = sel_ff;
      cmd.post_mark = mark_ff;
      unique case (state_ff)
         S_CLR: begin
            cmd.clr_wr = 1'b1;
            if (sts.clr_last) begin
               state_in = post_ff ? S_DONE : S_IDLE;
               post_in  = 1'b0;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.ld_req = 1'b1;
               mark_in    = 1'b0;
               sel_in     = 1'b0;
               unique case (req_opcode)
                  OP_BEGIN: begin
                     cmd.ang_load = 1'b1;
                     post_in      = 1'b1;
                     state_in     = S_CLR;
                  end
                  OP_RANGE: state_in = S_RNG;
                  OP_READ:  state_in = S_RD0;
                  OP_NONE:  state_in = S_DONE;
                  default:  state_in = S_DONE;
               endcase
            end
         end
         S_RD0: begin
            cmd.rd_cell = 1'b1;
            state_in    = S_RD1;
         end
         S_RD1: state_in = S_DONE;
         S_RNG: begin
            cmd.ang_step = 1'b1;
            state_in = sts.in_range ? S_TRIG : S_DONE;
         end
         S_TRIG: begin
            cmd.trig = 1'b1;
            state_in = S_PROD;
         end
         S_PROD: begin
            cmd.prod = 1'b1;
            state_in = S_NUM;
         end
         S_NUM: begin
            cmd.num_start = 1'b1;
            state_in      = S_DIV;
         end
         S_DIV: begin
            if (!sts.div_done) begin
               cmd.div_step = 1'b1;
            end else begin
               cmd.g_save = 1'b1;
               sel_in     = 1'b1;
               state_in   = sel_ff ? S_NDIV : S_TRIG;
            end
         end
         S_NDIV: begin
            if (sts.grid_ok) begin
               cmd.nd_start = 1'b1;
               mark_in      = 1'b1;
               state_in     = S_NSAV;
            end else begin
               state_in = S_DONE;
            end
         end
         S_NSAV: begin
            if (!sts.div_done) begin
               cmd.div_step = 1'b1;
            end else begin
               cmd.n_save = 1'b1;
               state_in   = S_CELL;
            end
         end
         S_CELL: begin
            cmd.cell_eval = 1'b1;
            state_in = sts.cell_in ? S_SC : S_NEXT;
         end
         S_SC: begin
            cmd.sc_mul = 1'b1;
            state_in   = S_CHK;
         end
         S_CHK: begin
            if (sts.scs_gt) begin
               state_in = S_NEXT;
            end else begin
               cmd.need_init = 1'b1;
               state_in      = S_BS0;
            end
         end
         S_BS0: begin
            if (sts.bs_more) begin
               cmd.bs_mul = 1'b1;
               state_in   = S_BS1;
            end else begin
               state_in = S_RMW0;
            end
         end
         S_BS1: begin
            cmd.bs_cmp = 1'b1;
            state_in   = S_BS0;
         end
         S_RMW0: begin
            cmd.rmw_rd = 1'b1;
            state_in   = S_RMW1;
         end
         S_RMW1: begin
            cmd.rmw_wr = 1'b1;
            state_in   = S_NEXT;
         end
         S_NEXT: begin
            if (sts.win_last) begin
               state_in = S_DONE;
            end else begin
               cmd.win_next = 1'b1;
               state_in     = S_CELL;
            end
         end
         S_DONE: begin
            if (slot_free) begin
               cmd.post = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // result valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.post) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         sel_ff       <= 1'b0;
         mark_ff      <= 1'b0;
         post_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sel_ff       <= sel_in;
         mark_ff      <= mark_in;
         post_ff      <= post_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // checks
   `ASSERT_PROP(a_post_free, clock, reset, cmd.post |-> slot_free)
   `ASSERT_PROP(a_rsp_from_post, clock, reset, $rose(rsp_valid_ff) |-> $past(cmd.post))
   `ASSERT_PROP(a_one_port_use, clock, reset,
                $onehot0({cmd.clr_wr, cmd.rd_cell, cmd.rmw_rd, cmd.rmw_wr}))
   `ASSERT_NEVER(a_step_after_done, clock, reset, cmd.div_step && sts.div_done)

endmodule

FILE: design/laser_scan_costmap_inflation.sv
// top level of the laser scan costmap with obstacle inflation
// depends on lsci_pkg, lsci_ctrl and lsci_dp
//
// channel | ports                           | direction
// req     | req_valid/ready, opcode, fields | in
// rsp     | rsp_valid/ready, cost, marked   | out
// csr     | csr_valid/ready, index, wdata   | in
//
// reset clears all 65536 cells, one a cycle, items wait; a begin-scan item repeats it
// a read goes through the registered ram read; a range sample runs two divisions,
// a hit one more for the window size, then each window cell takes a binary search
// of up to 7 steps and a read-modify-write, over a window of up to 33 by 33
// the next item is taken while an earlier result waits in the output register
module laser_scan_costmap_inflation import lsci_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_opcode,
   input  logic [15:0]       req_range_value,
   input  logic [31:0]       req_start_angle,
   input  logic [7:0]        req_cell_x,
   input  logic [7:0]        req_cell_y,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [COST_W-1:0] rsp_cell_cost,
   output logic              rsp_obstacle_marked,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [CSR_IW-1:0] csr_index,
   input  logic [31:0]       csr_wdata
);

   cmd_type cmd;
   sts_type sts;

   // register writes are always taken
   assign csr_ready = 1'b1;

   lsci_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_opcode (req_opcode),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .cmd        (cmd),
      .sts        (sts)
   );

   lsci_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_opcode          (req_opcode),
      .req_range_value     (req_range_value),
      .req_start_angle     (req_start_angle),
      .req_cell_x          (req_cell_x),
      .req_cell_y          (req_cell_y),
      .csr_valid           (csr_valid),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .rsp_cell_cost       (rsp_cell_cost),
      .rsp_obstacle_marked (rsp_obstacle_marked)
   );

endmodule

FILE: tb/sv/costmap_checker.sv
`timescale 1ns / 1ps
// transfer monitor, cost grid predictor and result comparison for the costmap block
// depends on lsci_pkg for the channel widths and the opcode and register codes
module costmap_checker import lsci_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic [1:0]        req_opcode,
   input  logic [15:0]       req_range_value,
   input  logic [31:0]       req_start_angle,
   input  logic [7:0]        req_cell_x,
   input  logic [7:0]        req_cell_y,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic [COST_W-1:0] rsp_cell_cost,
   input  logic              rsp_obstacle_marked,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [CSR_IW-1:0] csr_index,
   input  logic [31:0]       csr_wdata,
   output int                fail_count,
   output int                pending
);

   typedef struct packed {
      logic [COST_W-1:0] cost;
      logic              marked;
   } cell_result_type;

   localparam int TBL [0:64] = '{
      0, 402, 804, 1205, 1606, 2006, 2404, 2801, 3196, 3590,
      3981, 4370, 4756, 5139, 5520, 5897, 6270, 6639, 7005, 7366,
      7723, 8076, 8423, 8765, 9102, 9434, 9760, 10080, 10394, 10702,
      11003, 11297, 11585, 11866, 12140, 12406, 12665, 12916, 13160, 13395,
      13623, 13842, 14053, 14256, 14449, 14635, 14811, 14978, 15137, 15286,
      15426, 15557, 15679, 15791, 15893, 15986, 16069, 16143, 16207, 16261,
      16305, 16340, 16364, 16379, 16384
   };

   cell_result_type   expected_results[$];
   logic [COST_W-1:0] cost_map [0:65535];
   logic [31:0]       scan_angle;
   logic [15:0]       lim_lo, lim_hi, cell_sz, radius;
   logic [31:0]       step;
   logic [23:0]       org_x, org_y;

   // interpolated quarter wave, q14
   function automatic longint quarter_sin(logic [31:0] p);
      logic [31:0] i;
      longint      frac;
      i    = p >> 24;
      frac = longint'(p[23:0]);
      if (i >= 64) return TBL[64];
      return TBL[i] + (((TBL[i+1] - TBL[i]) * frac) >>> 24);
   endfunction

   function automatic longint sin_q14(logic [31:0] a);
      longint v;
      if (a[30]) v = quarter_sin(32'h4000_0000 - {2'b00, a[29:0]});
      else       v = quarter_sin({2'b00, a[29:0]});
      return a[31] ? -v : v;
   endfunction

   // linear cost fall-off around a marked cell
   task automatic inflate_around(longint gx, longint gy, longint cs);
      longint n, nx, ny, s, need, kr;
      int     lo, hi, mid;
      if (radius == 0) return;
      n = radius / cs;
      if (n > MAX_INFL) n = MAX_INFL;
      for (longint dx = -n; dx <= n; dx++) begin
         for (longint dy = -n; dy <= n; dy++) begin
            nx = gx + dx;
            ny = gy + dy;
            if (nx < 0 || nx > 255 || ny < 0 || ny > 255) continue;
            s = dx * dx + dy * dy;
            if (s * cs * cs > longint'(radius) * radius) continue;
            need = 10000 * cs * cs * s;
            lo = 0;
            hi = 100;
            while (lo < hi) begin
               mid = (lo + hi) / 2;
               kr  = longint'(mid) * radius;
               if (kr * kr >= need) hi = mid;
               else lo = mid + 1;
            end
            if (7'(100 - lo) > cost_map[ny * 256 + nx])
               cost_map[ny * 256 + nx] = 7'(100 - lo);
         end
      end
   endtask

   task automatic predict_item(output cell_result_type res);
      logic [31:0] a;
      longint      cs, px, py, gx, gy;
      res = '0;
      case (req_opcode)
         OP_BEGIN: begin
            foreach (cost_map[i]) cost_map[i] = '0;
            scan_angle = req_start_angle;
         end
         OP_RANGE: begin
            a = scan_angle;
            scan_angle = scan_angle + step;
            if (req_range_value >= lim_lo && req_range_value <= lim_hi) begin
               cs = (cell_sz == 0) ? 1 : cell_sz;
               px = longint'(req_range_value) * sin_q14(a + 32'h4000_0000)
                  - longint'($signed(org_x)) * 16384;
               py = longint'(req_range_value) * sin_q14(a)
                  - longint'($signed(org_y)) * 16384;
               gx = px / (cs * 16384);
               gy = py / (cs * 16384);
               if (gx >= 0 && gx < 256 && gy >= 0 && gy < 256) begin
                  cost_map[gy * 256 + gx] = COST_MAX;
                  inflate_around(gx, gy, cs);
                  res.marked = 1'b1;
               end
            end
         end
         OP_READ: res.cost = cost_map[{req_cell_y, req_cell_x}];
         default: ;
      endcase
   endtask

   initial begin
      fail_count = 0;
      pending    = 0;
      foreach (cost_map[i]) cost_map[i] = '0;
   end

   always @(posedge clock) begin
      cell_result_type exp_r, new_r;
      if (reset) begin
         scan_angle = '0;
         lim_lo     = 16'd0;
         lim_hi     = 16'hFFFF;
         step       = '0;
         org_x      = '0;
         org_y      = '0;
         cell_sz    = 16'd26;
         radius     = 16'd256;
      end else begin
         // result transfer against the oldest expectation
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result cost %0d marked %0d", $time,
                        rsp_cell_cost, rsp_obstacle_marked);
               fail_count++;
            end else begin
               exp_r = expected_results.pop_front();
               if (rsp_cell_cost !== exp_r.cost) begin
                  $display("%0t: cell_cost expected %0d actual %0d", $time,
                           exp_r.cost, rsp_cell_cost);
                  fail_count++;
               end
               if (rsp_obstacle_marked !== exp_r.marked) begin
                  $display("%0t: obstacle_marked expected %0d actual %0d", $time,
                           exp_r.marked, rsp_obstacle_marked);
                  fail_count++;
               end
            end
         end
         // register write transfer
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_RANGE_LO: lim_lo  = csr_wdata[15:0];
               REG_RANGE_HI: lim_hi  = csr_wdata[15:0];
               REG_ASTEP:    step    = csr_wdata;
               REG_ORG_X:    org_x   = csr_wdata[23:0];
               REG_ORG_Y:    org_y   = csr_wdata[23:0];
               REG_CELL:     cell_sz = csr_wdata[15:0];
               REG_RADIUS:   radius  = csr_wdata[15:0];
               default: ;
            endcase
         end
         // request transfer
         if (req_valid && req_ready) begin
            predict_item(new_r);
            expected_results.push_back(new_r);
         end
      end
      pending <= expected_results.size();
   end

endmodule

FILE: tb/sv/tb_laser_scan_costmap_inflation.sv
`timescale 1ns / 1ps
// stimulus and verdict for the laser scan costmap inflation block
// depends on lsci_pkg, the block and costmap_checker
module tb_laser_scan_costmap_inflation;
   import lsci_pkg::*;

   // index that no register answers to
   localparam logic [CSR_IW-1:0] REG_UNUSED = 3'd7;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [1:0]        req_opcode = OP_READ;
   logic [15:0]       req_range_value = '0;
   logic [31:0]       req_start_angle = '0;
   logic [7:0]        req_cell_x = '0;
   logic [7:0]        req_cell_y = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [COST_W-1:0] rsp_cell_cost;
   logic              rsp_obstacle_marked;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [CSR_IW-1:0] csr_index = '0;
   logic [31:0]       csr_wdata = '0;
   int                fail_count;
   int                pending;
   bit                idle_on = 1'b1;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   laser_scan_costmap_inflation dut (.*);

   costmap_checker chk (.*);

   // receiver stalls
   always @(posedge clock)
      rsp_ready <= !idle_on || ($urandom_range(99) >= 34);

   task automatic send_item(logic [1:0] op, logic [15:0] rng, logic [31:0] ang,
                            logic [7:0] x, logic [7:0] y);
      if (idle_on && $urandom_range(99) < 34) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_opcode      <= op;
      req_range_value <= rng;
      req_start_angle <= ang;
      req_cell_x      <= x;
      req_cell_y      <= y;
      req_valid       <= 1'b1;
      do @(posedge clock); while (!req_ready);
   endtask

   // hold the sender until every expected result has come
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic write_reg(logic [CSR_IW-1:0] idx, logic [31:0] data);
      csr_index <= idx;
      csr_wdata <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      int cs, kind;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: default registers
      send_item(OP_READ, 16'd0, 32'd0, 8'd0, 8'd0);
      send_item(OP_READ, 16'hFFFF, 32'hFFFF_FFFF, 8'd255, 8'd255);
      send_item(OP_NONE, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
      send_item(OP_BEGIN, 16'd0, 32'd0, 8'd0, 8'd0);
      send_item(OP_RANGE, 16'd256, 32'd0, 8'd0, 8'd0);
      send_item(OP_READ, 16'd0, 32'd0, 8'd9, 8'd0);
      send_item(OP_READ, 16'd0, 32'd0, 8'd10, 8'd0);
      send_item(OP_READ, 16'd0, 32'd0, 8'd18, 8'd0);
      send_item(OP_RANGE, 16'd0, 32'd0, 8'd0, 8'd0);
      send_item(OP_RANGE, 16'hFFFF, 32'd0, 8'd0, 8'd0);
      // zero cell size and zero radius
      drain();
      write_reg(REG_CELL, 32'd0);
      write_reg(REG_RADIUS, 32'd0);
      write_reg(REG_ASTEP, 32'h4000_0000);
      send_item(OP_RANGE, 16'd200, 32'd0, 8'd0, 8'd0);
      send_item(OP_RANGE, 16'd100, 32'd0, 8'd0, 8'd0);
      send_item(OP_READ, 16'd0, 32'd0, 8'd200, 8'd0);
      send_item(OP_READ, 16'd0, 32'd0, 8'd0, 8'd100);
      // range limits and extreme origins
      drain();
      write_reg(REG_RANGE_LO, 32'd100);
      write_reg(REG_RANGE_HI, 32'd200);
      write_reg(REG_ASTEP, 32'h8000_0000);
      write_reg(REG_ORG_X, 32'h0080_0000);
      write_reg(REG_ORG_Y, 32'h007F_FFFF);
      send_item(OP_RANGE, 16'd50, 32'd0, 8'd0, 8'd0);
      send_item(OP_RANGE, 16'd201, 32'd0, 8'd0, 8'd0);
      send_item(OP_RANGE, 16'd150, 32'd0, 8'd0, 8'd0);
      // widest window, clipped at the edge
      drain();
      write_reg(REG_RANGE_LO, 32'd0);
      write_reg(REG_RANGE_HI, 32'hFFFF);
      write_reg(REG_ASTEP, 32'h7FFF_FFFF);
      write_reg(REG_ORG_X, 32'd0);
      write_reg(REG_ORG_Y, 32'd0);
      write_reg(REG_CELL, 32'd1);
      write_reg(REG_RADIUS, 32'hFFFF);
      send_item(OP_RANGE, 16'd5, 32'd0, 8'd0, 8'd0);
      send_item(OP_READ, 16'd0, 32'd0, 8'd12, 8'd9);
      drain();
      write_reg(REG_CELL, 32'hFFFF);
      write_reg(REG_RADIUS, 32'd1);
      write_reg(REG_UNUSED, 32'hFFFF_FFFF);
      send_item(OP_RANGE, 16'hFFFF, 32'd0, 8'd0, 8'd0);
      send_item(OP_READ, 16'd0, 32'd0, 8'd0, 8'd0);

      // random phases, robot at the grid centre, hits on a ring
      for (int ph = 0; ph < 4; ph++) begin
         drain();
         idle_on = (ph != 1);
         cs = (ph == 3) ? 1 : $urandom_range(8, 64);
         write_reg(REG_CELL, cs);
         write_reg(REG_RADIUS, $urandom_range(1, 3 * cs));
         write_reg(REG_ORG_X, -(cs * 128));
         write_reg(REG_ORG_Y, -(cs * 128));
         write_reg(REG_RANGE_LO, $urandom_range(0, 4 * cs));
         write_reg(REG_RANGE_HI, (ph == 2) ? 65535 : $urandom_range(13 * cs, 65535));
         write_reg(REG_ASTEP, (ph == 0) ? $urandom : 32'd11930465 * $urandom_range(1, 40));
         send_item(OP_BEGIN, 16'(16'($urandom)), $urandom, 8'($urandom), 8'($urandom));
         for (int n = 0; n < 125; n++) begin
            kind = $urandom_range(99);
            if (kind < 48)
               send_item(OP_RANGE, 16'(cs * $urandom_range(5, 15)), $urandom,
                         8'($urandom), 8'($urandom));
            else if (kind < 55)
               send_item(OP_RANGE, 16'($urandom), $urandom, 8'($urandom), 8'($urandom));
            else if (kind < 85)
               send_item(OP_READ, 16'($urandom), $urandom,
                         8'($urandom_range(112, 144)), 8'($urandom_range(112, 144)));
            else if (kind < 95)
               send_item(OP_READ, 16'($urandom), $urandom, 8'($urandom), 8'($urandom));
            else
               send_item(OP_NONE, 16'($urandom), $urandom, 8'($urandom), 8'($urandom));
         end
      end

      drain();
      repeat (50) @(posedge clock);
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   // run limit
   initial begin
      #60_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
